// ===== hw/rtl/wlcs_pkg.sv =====
// Shared types and constants for the weighted LCS delete-sum core.
`default_nettype none

package wlcs_pkg;

    localparam int CHAR_W          = 8;
    localparam int CHAR_MAX        = 255;
    localparam int DELETE_W        = 15;
    localparam int DELETE_MAX      = 32767;
    localparam int MAX_LEN_DEFAULT = 64;

    typedef enum logic [2:0] {
        S_LOAD,
        S_START,
        S_ROW,
        S_CELL,
        S_FIN,
        S_RES
    } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/wlcs_in_if.sv =====
// Character input channel: valid/ready with select, byte and end-of-pair mark.
`default_nettype none

interface wlcs_in_if;
    logic                         valid;
    logic                         ready;
    logic                         string_select;
    logic [wlcs_pkg::CHAR_W-1:0]  character;
    logic                         last_of_pair;

    modport source (output valid, output string_select, output character,
                    output last_of_pair, input ready);
    modport sink   (input valid, input string_select, input character,
                    input last_of_pair, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/wlcs_out_if.sv =====
// Result output channel: valid/ready with delete sum and overflow flag.
`default_nettype none

interface wlcs_out_if;
    logic                          valid;
    logic                          ready;
    logic [wlcs_pkg::DELETE_W-1:0] delete_sum;
    logic                          overflow;

    modport source (output valid, output delete_sum, output overflow, input ready);
    modport sink   (input valid, input delete_sum, input overflow, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/wlcs_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
`default_nettype none

module wlcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/wlcs_cell.sv =====
// One weighted LCS cell: max of up and left, or diagonal plus code on a match.
`default_nettype none

module wlcs_cell #(
    parameter int DP_W = 14
) (
    input  wire logic [DP_W-1:0]             up,
    input  wire logic [DP_W-1:0]             left,
    input  wire logic [DP_W-1:0]             diag,
    input  wire logic [wlcs_pkg::CHAR_W-1:0] c,
    input  wire logic [wlcs_pkg::CHAR_W-1:0] s,
    output logic      [DP_W-1:0]             best
);

    logic [DP_W-1:0] max_ul;
    logic [DP_W:0]   diag_sum;

    always_comb
    begin
        max_ul   = (up > left) ? up : left;
        diag_sum = {1'b0, diag} + (DP_W + 1)'(c);
        if ((c == s) && (diag_sum > {1'b0, max_ul}))
        begin
            best = diag_sum[DP_W-1:0];
        end
        else
        begin
            best = max_ul;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/weighted_lcs_delete_sum_core.sv =====
// Weighted LCS delete-sum core: loads two byte strings, returns least delete code sum.
// Loading: one character per cycle, ready every cycle while loading.
// After end-of-pair: DP at one cell per cycle, plus an S_ROW step per row, through
// the shared cell unit and DP row RAM; the result register loads when output is free.
// Empty string skips the DP: S_START goes straight to S_FIN, then S_RES.
// Reset (rst_n low, async): lengths, sums, flags, sequencer and output valid cleared.
`default_nettype none

module weighted_lcs_delete_sum_core #(
    parameter int MAX_LEN = wlcs_pkg::MAX_LEN_DEFAULT
) (
    input wire logic   clk,
    input wire logic   rst_n,
    wlcs_in_if.sink    chars,
    wlcs_out_if.source result
);

    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int DP_W  = $clog2(wlcs_pkg::CHAR_MAX * MAX_LEN + 1);
    localparam int SUM_W = $clog2(2 * wlcs_pkg::CHAR_MAX * MAX_LEN + 1);
    localparam int RES_W = (SUM_W > wlcs_pkg::DELETE_W) ? SUM_W : wlcs_pkg::DELETE_W;

    wlcs_pkg::state_t state_reg, state_next;

    logic [LEN_W-1:0]  len_a_reg, len_b_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic              drop_reg;
    logic [IDX_W-1:0]  i_reg, j_reg;
    logic              pend_reg, pend_first_reg, pend_row0_reg;
    logic [IDX_W-1:0]  pend_j_reg;
    logic [DP_W-1:0]   left_reg, diag_reg;
    logic              out_valid_reg, out_ovf_reg;
    logic [wlcs_pkg::DELETE_W-1:0] out_sum_reg;

    logic                        accept, room_a, room_b, last_j, last_i, res_fire;
    logic [LEN_W-1:0]            len_a_m1, len_b_m1;
    logic                        a_we, b_we, a_re, b_re, dp_re;
    logic [wlcs_pkg::CHAR_W-1:0] a_rdata, b_rdata;
    logic [DP_W-1:0]             dp_rdata;
    logic [DP_W-1:0]             cell_up, cell_left, cell_diag, cell_best;
    logic [RES_W-1:0]            diff;
    logic [wlcs_pkg::DELETE_W-1:0] delete_val;

    assign accept   = chars.valid && chars.ready;
    assign room_a   = len_a_reg < LEN_W'(MAX_LEN);
    assign room_b   = len_b_reg < LEN_W'(MAX_LEN);
    assign len_a_m1 = len_a_reg - LEN_W'(1);
    assign len_b_m1 = len_b_reg - LEN_W'(1);
    assign last_j   = j_reg == len_b_m1[IDX_W-1:0];
    assign last_i   = i_reg == len_a_m1[IDX_W-1:0];
    assign res_fire = (state_reg == wlcs_pkg::S_RES) && (!out_valid_reg || result.ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wlcs_pkg::S_LOAD:
            begin
                if (accept && chars.last_of_pair)
                begin
                    state_next = wlcs_pkg::S_START;
                end
            end
            wlcs_pkg::S_START:
            begin
                if ((len_a_reg == '0) || (len_b_reg == '0))
                begin
                    state_next = wlcs_pkg::S_FIN;
                end
                else
                begin
                    state_next = wlcs_pkg::S_ROW;
                end
            end
            wlcs_pkg::S_ROW:
            begin
                state_next = wlcs_pkg::S_CELL;
            end
            wlcs_pkg::S_CELL:
            begin
                if (last_j)
                begin
                    state_next = last_i ? wlcs_pkg::S_FIN : wlcs_pkg::S_ROW;
                end
            end
            wlcs_pkg::S_FIN:
            begin
                state_next = wlcs_pkg::S_RES;
            end
            wlcs_pkg::S_RES:
            begin
                if (res_fire)
                begin
                    state_next = wlcs_pkg::S_LOAD;
                end
            end
            default:
            begin
                state_next = wlcs_pkg::S_LOAD;
            end
        endcase
    end

    // outputs and memory controls
    always_comb
    begin
        chars.ready = state_reg == wlcs_pkg::S_LOAD;
        a_we  = accept && !chars.string_select && room_a;
        b_we  = accept && chars.string_select && room_b;
        a_re  = state_reg == wlcs_pkg::S_ROW;
        b_re  = state_reg == wlcs_pkg::S_CELL;
        dp_re = state_reg == wlcs_pkg::S_CELL;
    end

    assign result.valid      = out_valid_reg;
    assign result.delete_sum = out_sum_reg;
    assign result.overflow   = out_ovf_reg;

    wlcs_ram #(.WIDTH(wlcs_pkg::CHAR_W), .DEPTH(MAX_LEN)) u_ram_a (
        .clk   (clk),
        .we    (a_we),
        .waddr (len_a_reg[IDX_W-1:0]),
        .wdata (chars.character),
        .re    (a_re),
        .raddr (i_reg),
        .rdata (a_rdata)
    );

    wlcs_ram #(.WIDTH(wlcs_pkg::CHAR_W), .DEPTH(MAX_LEN)) u_ram_b (
        .clk   (clk),
        .we    (b_we),
        .waddr (len_b_reg[IDX_W-1:0]),
        .wdata (chars.character),
        .re    (b_re),
        .raddr (j_reg),
        .rdata (b_rdata)
    );

    // entry k holds dp_row[k+1]; dp_row[0] is always zero
    wlcs_ram #(.WIDTH(DP_W), .DEPTH(MAX_LEN)) u_ram_dp (
        .clk   (clk),
        .we    (pend_reg),
        .waddr (pend_j_reg),
        .wdata (cell_best),
        .re    (dp_re),
        .raddr (j_reg),
        .rdata (dp_rdata)
    );

    // first row sees a cleared DP row, first column a zero left and diagonal
    assign cell_up   = pend_row0_reg ? '0 : dp_rdata;
    assign cell_left = pend_first_reg ? '0 : left_reg;
    assign cell_diag = pend_first_reg ? '0 : diag_reg;

    wlcs_cell #(.DP_W(DP_W)) u_cell (
        .up   (cell_up),
        .left (cell_left),
        .diag (cell_diag),
        .c    (a_rdata),
        .s    (b_rdata),
        .best (cell_best)
    );

    always_comb
    begin
        diff = RES_W'(sum_reg) - (RES_W'(left_reg) << 1);
        if (diff > RES_W'(wlcs_pkg::DELETE_MAX))
        begin
            delete_val = wlcs_pkg::DELETE_W'(wlcs_pkg::DELETE_MAX);
        end
        else
        begin
            delete_val = diff[wlcs_pkg::DELETE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= wlcs_pkg::S_LOAD;
            len_a_reg      <= '0;
            len_b_reg      <= '0;
            sum_reg        <= '0;
            drop_reg       <= 1'b0;
            i_reg          <= '0;
            j_reg          <= '0;
            pend_reg       <= 1'b0;
            pend_first_reg <= 1'b0;
            pend_row0_reg  <= 1'b0;
            pend_j_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_reg       <= state_reg == wlcs_pkg::S_CELL;
            pend_first_reg <= j_reg == '0;
            pend_row0_reg  <= i_reg == '0;
            pend_j_reg     <= j_reg;

            if (accept)
            begin
                if (!chars.string_select)
                begin
                    if (room_a)
                    begin
                        len_a_reg <= len_a_reg + LEN_W'(1);
                        sum_reg   <= sum_reg + SUM_W'(chars.character);
                    end
                    else
                    begin
                        drop_reg <= 1'b1;
                    end
                end
                else
                begin
                    if (room_b)
                    begin
                        len_b_reg <= len_b_reg + LEN_W'(1);
                        sum_reg   <= sum_reg + SUM_W'(chars.character);
                    end
                    else
                    begin
                        drop_reg <= 1'b1;
                    end
                end
            end

            if (state_reg == wlcs_pkg::S_START)
            begin
                i_reg <= '0;
            end
            if (state_reg == wlcs_pkg::S_ROW)
            begin
                j_reg <= '0;
            end
            if (state_reg == wlcs_pkg::S_CELL)
            begin
                if (last_j)
                begin
                    i_reg <= i_reg + IDX_W'(1);
                end
                else
                begin
                    j_reg <= j_reg + IDX_W'(1);
                end
            end

            if (res_fire)
            begin
                out_valid_reg <= 1'b1;
                len_a_reg     <= '0;
                len_b_reg     <= '0;
                sum_reg       <= '0;
                drop_reg      <= 1'b0;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept && chars.last_of_pair)
        begin
            left_reg <= '0;
        end
        else if (pend_reg)
        begin
            left_reg <= cell_best;
            diag_reg <= cell_up;
        end
        if (res_fire)
        begin
            out_sum_reg <= delete_val;
            out_ovf_reg <= drop_reg;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/wlcs_checker.sv =====
// Port-level assertions for the weighted LCS delete-sum core, with bind.
`default_nettype none

module wlcs_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic                          in_last,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [wlcs_pkg::DELETE_W-1:0] out_delete_sum,
    input wire logic                          out_overflow
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped before transfer");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_delete_sum) && $stable(out_overflow))
        else $error("result payload changed while stalled");

    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !in_ready)
        else $error("input ready right after end-of-pair transfer");

    a_result_after_compute: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a computation");

endmodule

bind weighted_lcs_delete_sum_core wlcs_checker u_wlcs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (chars.valid),
    .in_ready       (chars.ready),
    .in_last        (chars.last_of_pair),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .out_delete_sum (result.delete_sum),
    .out_overflow   (result.overflow)
);

`default_nettype wire

// ===== sim/weighted_lcs_delete_sum_core_tb.sv =====
// Testbench for the weighted LCS delete-sum core: directed pairs, then random pairs.
module weighted_lcs_delete_sum_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LEN      = wlcs_pkg::MAX_LEN_DEFAULT;
    localparam int ITEM_TARGET  = 1475;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 50;
    localparam int DIRECTED_N   = 23;

    typedef enum int {
        ALPHA_FULL,
        ALPHA_FEW,
        ALPHA_EDGE,
        ALPHA_SPLIT
    } alphabet_t;

    typedef struct packed {
        logic [wlcs_pkg::DELETE_W-1:0] delete_sum;
        logic                          overflow;
    } sum_result_t;

    typedef struct packed {
        bit                          sel;
        bit [wlcs_pkg::CHAR_W-1:0]   ch;
        bit                          last;
        bit                          typed;
        bit [wlcs_pkg::DELETE_W-1:0] delete_sum;
        bit                          overflow;
    } directed_row_t;

    logic clk;
    logic rst_n;
    int   cycles;
    int   mismatches;
    int   items_sent;
    bit   steady;

    wlcs_in_if  chars_if ();
    wlcs_out_if result_if ();

    weighted_lcs_delete_sum_core #(.MAX_LEN(MAX_LEN)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars_if),
        .result (result_if)
    );

    // predictor state
    bit [wlcs_pkg::CHAR_W-1:0] first_chars [MAX_LEN];
    bit [wlcs_pkg::CHAR_W-1:0] second_chars [MAX_LEN];
    int                        first_len;
    int                        second_len;
    int                        char_total;
    bit                        dropped;

    sum_result_t pending_sums [$];

    // directed pairs; typed expectations: empty string, equal strings, extremes
    directed_row_t directed_rows [DIRECTED_N] = '{
        '{1'b0, 8'd255, 1'b1, 1'b1, 15'd255, 1'b0},
        '{1'b1, 8'd0,   1'b1, 1'b1, 15'd0,   1'b0},
        '{1'b1, 8'd200, 1'b0, 1'b0, 15'd0,   1'b0},
        '{1'b1, 8'd55,  1'b1, 1'b1, 15'd255, 1'b0},
        '{1'b0, 8'd97,  1'b0, 1'b0, 15'd0,   1'b0},
        '{1'b1, 8'd97,  1'b1, 1'b1, 15'd0,   1'b0},
        '{1'b0, 8'd255, 1'b0, 1'b0, 15'd0,   1'b0},
        '{1'b1, 8'd255, 1'b1, 1'b1, 15'd0,   1'b0},
        '{1'b0, 8'd1,   1'b0, 1'b0, 15'd0,   1'b0},
        '{1'b1, 8'd2,   1'b1, 1'b1, 15'd3,   1'b0},
        '{1'b0, 8'd115, 1'b0, 1'b0, 15'd0,   1'b0},
        '{1'b0, 8'd101, 1'b0, 1'b0, 15'd0,   1'b0},
        '{1'b0, 8'd97,  1'b0, 1'b0, 15'd0,   1'b0},
        '{1'b1, 8'd101, 1'b0, 1'b0, 15'd0,   1'b0},
        '{1'b1, 8'd97,  1'b0, 1'b0, 15'd0,   1'b0},
        '{1'b1, 8'd116, 1'b1, 1'b0, 15'd0,   1'b0},
        '{1'b0, 8'd97,  1'b0, 1'b0, 15'd0,   1'b0},
        '{1'b1, 8'd99,  1'b0, 1'b0, 15'd0,   1'b0},
        '{1'b0, 8'd98,  1'b0, 1'b0, 15'd0,   1'b0},
        '{1'b1, 8'd98,  1'b0, 1'b0, 15'd0,   1'b0},
        '{1'b0, 8'd99,  1'b0, 1'b0, 15'd0,   1'b0},
        '{1'b1, 8'd97,  1'b0, 1'b0, 15'd0,   1'b0},
        '{1'b1, 8'd128, 1'b1, 1'b0, 15'd0,   1'b0}
    };

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout at cycle %0d, %0d results outstanding", cycles,
                     pending_sums.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
        mismatches++;
    endtask

    function automatic int best_match_weight();
        int row [MAX_LEN+1];
        int diag;
        int up;
        int best;
        int c;
        for (int j = 0; j <= MAX_LEN; j++)
            row[j] = 0;
        for (int i = 0; i < first_len; i++)
        begin
            c    = first_chars[i];
            diag = 0;
            for (int j = 1; j <= second_len; j++)
            begin
                up   = row[j];
                best = (up > row[j-1]) ? up : row[j-1];
                if (c == second_chars[j-1] && diag + c > best)
                    best = diag + c;
                diag   = up;
                row[j] = best;
            end
        end
        return row[second_len];
    endfunction

    task automatic absorb_char(input bit sel, input bit [wlcs_pkg::CHAR_W-1:0] ch,
                               input bit last, input bit typed,
                               input sum_result_t typed_result);
        sum_result_t predicted;
        int          total;
        if (!sel)
        begin
            if (first_len < MAX_LEN)
            begin
                first_chars[first_len] = ch;
                first_len++;
                char_total += ch;
            end
            else
                dropped = 1'b1;
        end
        else
        begin
            if (second_len < MAX_LEN)
            begin
                second_chars[second_len] = ch;
                second_len++;
                char_total += ch;
            end
            else
                dropped = 1'b1;
        end
        if (last)
        begin
            total = char_total - 2 * best_match_weight();
            if (total > wlcs_pkg::DELETE_MAX)
                total = wlcs_pkg::DELETE_MAX;
            predicted.delete_sum = total[wlcs_pkg::DELETE_W-1:0];
            predicted.overflow   = dropped;
            pending_sums.push_back(typed ? typed_result : predicted);
            first_len  = 0;
            second_len = 0;
            char_total = 0;
            dropped    = 1'b0;
        end
    endtask

    task automatic send_char(input bit sel, input bit [wlcs_pkg::CHAR_W-1:0] ch,
                             input bit last, input bit typed,
                             input sum_result_t typed_result);
        steady = (items_sent >= 600 && items_sent < 850);
        while (!steady && $urandom_range(0, 99) < 25)
        begin
            chars_if.valid <= 1'b0;
            @(posedge clk);
        end
        chars_if.valid         <= 1'b1;
        chars_if.string_select <= sel;
        chars_if.character     <= ch;
        chars_if.last_of_pair  <= last;
        @(posedge clk);
        while (!chars_if.ready)
            @(posedge clk);
        absorb_char(sel, ch, last, typed, typed_result);
        items_sent++;
    endtask

    task automatic send_pair(input int first_n, input int second_n, input alphabet_t alpha);
        bit [wlcs_pkg::CHAR_W-1:0] few [3];
        bit [wlcs_pkg::CHAR_W-1:0] ch;
        bit                        sel;
        int                        left_first;
        int                        left_second;
        int                        n;
        left_first  = first_n;
        left_second = second_n;
        n           = first_n + second_n;
        for (int k = 0; k < 3; k++)
            few[k] = wlcs_pkg::CHAR_W'($urandom_range(0, wlcs_pkg::CHAR_MAX));
        for (int k = 0; k < n; k++)
        begin
            if (left_first == 0)
                sel = 1'b1;
            else if (left_second == 0)
                sel = 1'b0;
            else
                sel = ($urandom_range(0, left_first + left_second - 1) < left_second);
            if (sel)
                left_second--;
            else
                left_first--;
            case (alpha)
                ALPHA_FEW:   ch = few[$urandom_range(0, 2)];
                ALPHA_EDGE:  ch = $urandom_range(0, 1) ? {1'($urandom_range(0, 1)), 7'h7F}
                                                       : {1'($urandom_range(0, 1)), 7'h00};
                ALPHA_SPLIT: ch = sel ? 8'd254 : 8'd255;
                default:     ch = wlcs_pkg::CHAR_W'($urandom_range(0, wlcs_pkg::CHAR_MAX));
            endcase
            send_char(sel, ch, k == n - 1, 1'b0, '0);
        end
    endtask

    always @(posedge clk)
    begin
        sum_result_t want;
        if (result_if.valid && result_if.ready)
        begin
            if (pending_sums.size() == 0)
                report_mismatch("unexpected result, delete_sum",
                                int'(result_if.delete_sum), -1);
            else
            begin
                want = pending_sums.pop_front();
                if (result_if.delete_sum !== want.delete_sum)
                    report_mismatch("delete_sum", int'(result_if.delete_sum),
                                    int'(want.delete_sum));
                if (result_if.overflow !== want.overflow)
                    report_mismatch("overflow", int'(result_if.overflow),
                                    int'(want.overflow));
            end
        end
        result_if.ready <= steady || ($urandom_range(0, 99) >= 25);
    end

    initial
    begin
        int        r;
        int        pair_idx;
        int        na;
        int        nb;
        alphabet_t alpha;
        clk                    = 1'b0;
        rst_n                  = 1'b0;
        cycles                 = 0;
        mismatches             = 0;
        items_sent             = 0;
        steady                 = 1'b0;
        first_len              = 0;
        second_len             = 0;
        char_total             = 0;
        dropped                = 1'b0;
        chars_if.valid         = 1'b0;
        chars_if.string_select = 1'b0;
        chars_if.character     = '0;
        chars_if.last_of_pair  = 1'b0;
        result_if.ready        = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_N; i++)
            send_char(directed_rows[i].sel, directed_rows[i].ch, directed_rows[i].last,
                      directed_rows[i].typed,
                      {directed_rows[i].delete_sum, directed_rows[i].overflow});

        pair_idx = 0;
        while (items_sent < ITEM_TARGET)
        begin
            r     = $urandom_range(0, 99);
            alpha = alphabet_t'($urandom_range(0, 2));
            if (pair_idx == 0)
            begin
                // both strings full, first all 255 and second all 254, two extra dropped
                na    = MAX_LEN + 2;
                nb    = MAX_LEN;
                alpha = ALPHA_SPLIT;
            end
            else if (r < 80)
            begin
                na = $urandom_range(0, 10);
                nb = $urandom_range(0, 10);
            end
            else if (r < 88)
            begin
                na = $urandom_range(11, 30);
                nb = $urandom_range(11, 30);
            end
            else if (r < 94)
            begin
                na = $urandom_range(MAX_LEN + 1, MAX_LEN + 8);
                nb = $urandom_range(0, 8);
                if ($urandom_range(0, 1))
                begin
                    nb = na;
                    na = $urandom_range(0, 8);
                end
            end
            else
            begin
                na = $urandom_range(50, MAX_LEN);
                nb = $urandom_range(50, MAX_LEN);
            end
            if (na + nb == 0)
                na = 1;
            send_pair(na, nb, alpha);
            pair_idx++;
        end
        chars_if.valid <= 1'b0;

        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/wlcs_pkg.sv
hw/rtl/wlcs_in_if.sv
hw/rtl/wlcs_out_if.sv
hw/rtl/wlcs_ram.sv
hw/rtl/wlcs_cell.sv
hw/rtl/weighted_lcs_delete_sum_core.sv
hw/rtl/wlcs_checker.sv
sim/weighted_lcs_delete_sum_core_tb.sv
